@@ rtl/pvu_pkg.sv @@
// Package for the peak VU meter: item, command and result types, widths,
// constants and the elaboration-time mantissa dB function.
// No dependencies.
package pvu_pkg;

    localparam int SAMPLE_W            = 24;
    localparam int COEFF_W             = 16;
    localparam int ENV_W               = 32;
    localparam int ENV_SHIFT           = ENV_W - SAMPLE_W;
    localparam int DB_W                = 16;
    localparam int LZ_W                = 5;
    localparam int TAB_W               = 19;
    localparam int CFG_IDX_W           = 2;
    localparam int LOG_FRAC_BITS       = 20;
    localparam int LOG_TABLE_DEPTH_DEF = 64;
    localparam int CMD_QUEUE_DEPTH     = 2;
    localparam int RES_QUEUE_DEPTH     = 2;

    localparam logic [COEFF_W-1:0]         ATTACK_RESET   = 16'd65400;
    localparam logic [COEFF_W-1:0]         DECAY_RESET    = 16'd65531;
    localparam logic [ENV_W-1:0]           ENV_FLOOR      = 32'd2148;
    localparam logic [TAB_W-1:0]           DB_PER_OCT_Q16 = 19'd394566;
    localparam logic signed [DB_W-1:0]     LEVEL_FLOOR    = -16'sd25600;

    localparam logic [CFG_IDX_W-1:0] CFG_ATTACK = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DECAY  = 2'd1;

    typedef struct packed {
        logic                       func;
        logic signed [SAMPLE_W-1:0] sample;
        logic                       last;
    } t_in_item;

    typedef struct packed {
        logic signed [DB_W-1:0]  level_db;
        logic [SAMPLE_W-1:0]     envelope;
    } t_out_item;

    typedef enum logic {
        CMD_UPDATE,
        CMD_CLEAR
    } t_cmd_kind;

    typedef struct packed {
        t_cmd_kind           kind;
        logic [SAMPLE_W-1:0] peak;
    } t_cmd;

    typedef struct packed {
        logic                 valid;
        logic [CFG_IDX_W-1:0] index;
        logic [COEFF_W-1:0]   data;
    } t_cfg_wr;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_ENV,
        BK_NORM,
        BK_DB
    } t_back_state;

    // 20*log10(1 + idx/2^lb) in Q.16 via a 20-bit squaring log2
    function automatic logic [31:0] mantissa_db_q16(input int unsigned idx,
                                                    input int unsigned lb);
        logic [63:0] x;
        logic [63:0] lg;
        logic [63:0] prod;
        x  = ((64'(1) << lb) + 64'(idx)) << 30;
        x  = x >> lb;
        lg = '0;
        for (int k = 0; k < LOG_FRAC_BITS; k++) begin
            x  = (x * x) >> 30;
            lg = lg << 1;
            if (x >= (64'(2) << 30)) begin
                x  = x >> 1;
                lg = lg | 64'(1);
            end
        end
        prod = (lg * 64'(DB_PER_OCT_Q16) + (64'(1) << (LOG_FRAC_BITS - 1))) >> LOG_FRAC_BITS;
        return prod[31:0];
    endfunction

endpackage

@@ rtl/peak_vu_meter_db.sv @@
// Peak envelope VU meter with dB readout: top level, front end, command queue,
// back end and result queue. Depends on pvu_pkg, pvu_fifo, pvu_front, pvu_back.
// Closing and clear items pass the command queue and, one at a time, the back
// end's multiply, envelope, normalize and dB steps to the result queue. The dB
// step waits on a full result queue. Other samples are taken one per cycle
// while the command queue is not full. Sync reset empties both queues, zeroes
// the buffer peak and envelope and loads the default coefficients.
module peak_vu_meter_db import pvu_pkg::*; #(
    parameter int LOG_TABLE_DEPTH = LOG_TABLE_DEPTH_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 push,
    output logic                 full,
    input  t_in_item             i_in_item,
    output logic                 empty,
    input  logic                 pop,
    output t_out_item            o_out_item,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [COEFF_W-1:0]   i_cfg_data
);

    logic      cmd_push;
    t_cmd      cmd_in;
    logic      cmd_full;
    logic      cmd_pop;
    t_cmd      cmd_head;
    logic      cmd_empty;
    logic      res_push;
    t_out_item res_in;
    logic      res_full;
    t_cfg_wr   cfg_wr;

    assign o_cfg_ready  = 1'b1;
    assign cfg_wr.valid = i_cfg_valid;
    assign cfg_wr.index = i_cfg_index;
    assign cfg_wr.data  = i_cfg_data;
    assign full         = cmd_full;

    pvu_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .i_item     (i_in_item),
        .i_q_full   (cmd_full),
        .o_cmd_push (cmd_push),
        .o_cmd      (cmd_in)
    );

    pvu_fifo #(
        .T     (t_cmd),
        .DEPTH (CMD_QUEUE_DEPTH)
    ) u_cmd_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (cmd_push),
        .i_data  (cmd_in),
        .o_full  (cmd_full),
        .i_pop   (cmd_pop),
        .o_data  (cmd_head),
        .o_empty (cmd_empty)
    );

    pvu_back #(
        .LOG_TABLE_DEPTH (LOG_TABLE_DEPTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg_wr),
        .i_cmd       (cmd_head),
        .i_cmd_empty (cmd_empty),
        .o_cmd_pop   (cmd_pop),
        .i_res_full  (res_full),
        .o_res_push  (res_push),
        .o_res       (res_in)
    );

    pvu_fifo #(
        .T     (t_out_item),
        .DEPTH (RES_QUEUE_DEPTH)
    ) u_res_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_push),
        .i_data  (res_in),
        .o_full  (res_full),
        .i_pop   (pop),
        .o_data  (o_out_item),
        .o_empty (empty)
    );

    a_cmd_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd_push |-> !cmd_full)
        else $error("command issued into a full queue");

    a_cmd_pop_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd_pop |-> !cmd_empty)
        else $error("back end took a command from an empty queue");

    a_res_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        res_push |-> !res_full)
        else $error("result written into a full queue");

    a_floor_level: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_out_item.envelope == '0) |-> o_out_item.level_db == LEVEL_FLOOR)
        else $error("zero envelope without floor level");

    a_level_nonpos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> o_out_item.level_db <= 16'sd0)
        else $error("positive dB level");

endmodule

@@ rtl/pvu_fifo.sv @@
// Small register FIFO used for the command queue and the result queue.
// Depends on nothing but its type parameter.
module pvu_fifo #(
    parameter type T     = logic,
    parameter int  DEPTH = 2
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  T     i_data,
    output logic o_full,
    input  logic i_pop,
    output T     o_data,
    output logic o_empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    T                 r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             do_push;
    logic             do_pop;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_empty = (r_count == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_data  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

@@ rtl/pvu_front.sv @@
// Front end: accepts input items, tracks the buffer peak and issues
// update or clear commands. Depends on pvu_pkg.
module pvu_front import pvu_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_push,
    input  t_in_item i_item,
    input  logic     i_q_full,
    output logic     o_cmd_push,
    output t_cmd     o_cmd
);

    logic [SAMPLE_W-1:0] r_peak;
    logic [SAMPLE_W-1:0] n_peak;
    logic [SAMPLE_W-1:0] mag;
    logic [SAMPLE_W-1:0] peak_incl;
    logic                accept;

    assign accept    = i_push && !i_q_full;
    assign mag       = i_item.sample[SAMPLE_W-1] ? SAMPLE_W'(-i_item.sample)
                                                 : SAMPLE_W'(i_item.sample);
    assign peak_incl = (mag > r_peak) ? mag : r_peak;

    always_comb begin
        o_cmd_push = 1'b0;
        o_cmd.kind = CMD_UPDATE;
        o_cmd.peak = peak_incl;
        n_peak     = r_peak;
        if (accept) begin
            if (i_item.func) begin
                o_cmd_push = 1'b1;
                o_cmd.kind = CMD_CLEAR;
                n_peak     = '0;
            end else if (i_item.last) begin
                o_cmd_push = 1'b1;
                n_peak     = '0;
            end else begin
                n_peak     = peak_incl;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_peak <= '0;
        end else begin
            r_peak <= n_peak;
        end
    end

endmodule

@@ rtl/pvu_back.sv @@
// Back end: coefficient registers, envelope update and dB conversion
// sequencer. Depends on pvu_pkg.
module pvu_back import pvu_pkg::*; #(
    parameter int LOG_TABLE_DEPTH = LOG_TABLE_DEPTH_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_cfg_wr   i_cfg,
    input  t_cmd      i_cmd,
    input  logic      i_cmd_empty,
    output logic      o_cmd_pop,
    input  logic      i_res_full,
    output logic      o_res_push,
    output t_out_item o_res
);

    localparam int LB = $clog2(LOG_TABLE_DEPTH);

    logic [TAB_W-1:0] tab [LOG_TABLE_DEPTH];

    for (genvar g = 0; g < LOG_TABLE_DEPTH; g++) begin : g_tab
        assign tab[g] = TAB_W'(mantissa_db_q16(g, LB));
    end

    t_back_state            r_state;
    t_back_state            n_state;
    logic [COEFF_W-1:0]     r_attack;
    logic [COEFF_W-1:0]     r_decay;
    logic [ENV_W-1:0]       r_env;
    logic [ENV_W-1:0]       n_env;
    logic [ENV_W-1:0]       r_peak31;
    logic signed [48:0]     r_prod;
    logic signed [48:0]     n_prod;
    logic                   r_clear;
    logic [LZ_W-1:0]        r_lz;
    logic [LZ_W-1:0]        n_lz;
    logic [LB-1:0]          r_idx;
    logic [LB-1:0]          n_idx;
    logic                   r_floor;

    logic [ENV_W-1:0]       peak31;
    logic [COEFF_W-1:0]     coeff;
    logic signed [48:0]     coeff_ext;
    logic signed [48:0]     diff_ext;
    logic signed [32:0]     diff;
    logic signed [33:0]     env_sum;
    logic [ENV_W-1:0]       norm;
    logic [23:0]            neg;
    logic [DB_W-1:0]        mag;

    always_comb begin
        peak31    = {i_cmd.peak, {ENV_SHIFT{1'b0}}};
        coeff     = (peak31 > r_env) ? r_attack : r_decay;
        diff      = $signed({1'b0, r_env}) - $signed({1'b0, peak31});
        coeff_ext = $signed({33'd0, coeff});
        diff_ext  = $signed({{16{diff[32]}}, diff});
        n_prod    = coeff_ext * diff_ext;

        env_sum   = $signed({2'b00, r_peak31}) + $signed({r_prod[48], r_prod[48:16]});
        n_env     = r_clear ? '0 : env_sum[ENV_W-1:0];

        norm = r_env;
        n_lz = '0;
        if (norm[31:16] == '0) begin
            norm = norm << 16;
            n_lz = n_lz | LZ_W'(16);
        end
        if (norm[31:24] == '0) begin
            norm = norm << 8;
            n_lz = n_lz | LZ_W'(8);
        end
        if (norm[31:28] == '0) begin
            norm = norm << 4;
            n_lz = n_lz | LZ_W'(4);
        end
        if (norm[31:30] == '0) begin
            norm = norm << 2;
            n_lz = n_lz | LZ_W'(2);
        end
        if (norm[31] == 1'b0) begin
            norm = norm << 1;
            n_lz = n_lz | LZ_W'(1);
        end
        n_idx = norm[30 -: LB];

        neg = 24'(r_lz) * 24'(DB_PER_OCT_Q16) - 24'(tab[r_idx]);
        mag = DB_W'((neg + 24'd128) >> 8);

        o_res.envelope = r_env[ENV_W-1:ENV_SHIFT];
        o_res.level_db = r_floor ? LEVEL_FLOOR : $signed(DB_W'(0) - mag);

        o_cmd_pop  = 1'b0;
        o_res_push = 1'b0;
        n_state    = r_state;
        case (r_state)
            BK_IDLE: begin
                if (!i_cmd_empty) begin
                    o_cmd_pop = 1'b1;
                    n_state   = BK_ENV;
                end
            end
            BK_ENV: begin
                n_state = BK_NORM;
            end
            BK_NORM: begin
                n_state = BK_DB;
            end
            BK_DB: begin
                if (!i_res_full) begin
                    o_res_push = 1'b1;
                    n_state    = BK_IDLE;
                end
            end
            default: begin
                n_state = BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= BK_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_attack <= ATTACK_RESET;
            r_decay  <= DECAY_RESET;
            r_env    <= '0;
        end else begin
            if (i_cfg.valid) begin
                case (i_cfg.index)
                    CFG_ATTACK: r_attack <= i_cfg.data;
                    CFG_DECAY:  r_decay  <= i_cfg.data;
                    default: begin
                    end
                endcase
            end
            if (r_state == BK_ENV) begin
                r_env <= n_env;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == BK_IDLE) begin
            r_prod   <= n_prod;
            r_peak31 <= peak31;
            r_clear  <= (i_cmd.kind == CMD_CLEAR);
        end
        if (r_state == BK_NORM) begin
            r_lz    <= n_lz;
            r_idx   <= n_idx;
            r_floor <= (r_env < ENV_FLOOR);
        end
    end

endmodule
